@@ sv/upc_pkg.sv @@
package upc_pkg;

   localparam int CSR_DATA_WIDTH  = 16;
   localparam int CSR_INDEX_WIDTH = 1;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GAIN           = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_INVERSE_OFFSET = 1'd1;

   localparam logic [CSR_DATA_WIDTH-1:0] GAIN_RESET           = 16'd256;
   localparam logic [CSR_DATA_WIDTH-1:0] INVERSE_OFFSET_RESET = 16'd256;

   localparam int GAIN_SHIFT = 8;
   localparam int TERM_SHIFT = 16;

   localparam int ANGLE_BITS      = 32;
   localparam int CORDIC_STEPS    = 30;
   localparam int CORDIC_WIDTH    = 34;
   localparam int CORDIC_START    = 652032874;
   localparam int CORDIC_ROUND    = 8192;
   localparam int CORDIC_SHIFT    = 14;
   localparam int CORDIC_LATENCY  = CORDIC_STEPS + 2;
   localparam int SC_WIDTH        = 18;
   localparam int SC_ONE          = 65536;

   localparam int SCALE_LATENCY   = 3;
   localparam int ROTATE_LATENCY  = 4;

   typedef struct packed {
      logic [CSR_DATA_WIDTH-1:0] gain;
      logic [CSR_DATA_WIDTH-1:0] inverse_offset;
   } cfg_type;

   function automatic logic signed [CORDIC_WIDTH-1:0] cordic_atan(input int step);
      logic signed [CORDIC_WIDTH-1:0] v;
      case (step)
         0:  v = 34'sd536870912;
         1:  v = 34'sd316933406;
         2:  v = 34'sd167458907;
         3:  v = 34'sd85004756;
         4:  v = 34'sd42667331;
         5:  v = 34'sd21354465;
         6:  v = 34'sd10679838;
         7:  v = 34'sd5340245;
         8:  v = 34'sd2670163;
         9:  v = 34'sd1335087;
         10: v = 34'sd667544;
         11: v = 34'sd333772;
         12: v = 34'sd166886;
         13: v = 34'sd83443;
         14: v = 34'sd41722;
         15: v = 34'sd20861;
         16: v = 34'sd10430;
         17: v = 34'sd5215;
         18: v = 34'sd2608;
         19: v = 34'sd1304;
         20: v = 34'sd652;
         21: v = 34'sd326;
         22: v = 34'sd163;
         23: v = 34'sd81;
         24: v = 34'sd41;
         25: v = 34'sd20;
         26: v = 34'sd10;
         27: v = 34'sd5;
         28: v = 34'sd3;
         29: v = 34'sd1;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

@@ sv/upc_scale.sv @@
module upc_scale #(
   parameter int POS_WIDTH = 32
) (
   input  logic                        clock,
   input  upc_pkg::cfg_type            cfg,
   input  logic signed [POS_WIDTH-1:0] target [3],
   input  logic signed [POS_WIDTH-1:0] current [3],
   output logic signed [POS_WIDTH-1:0] err [3]
);
   import upc_pkg::*;

   localparam int DIFF_W  = POS_WIDTH + 1;
   localparam int PROD_W  = DIFF_W + CSR_DATA_WIDTH + 1;
   localparam int SHIFT_W = PROD_W - GAIN_SHIFT;
   localparam logic signed [POS_WIDTH-1:0] POS_MAX = {1'b0, {(POS_WIDTH-1){1'b1}}};
   localparam logic signed [POS_WIDTH-1:0] POS_MIN = {1'b1, {(POS_WIDTH-1){1'b0}}};

   for (genvar a = 0; a < 3; a++) begin : g_axis
      logic signed [DIFF_W-1:0]    diff_ff, diff_in;
      logic signed [PROD_W-1:0]    prod_ff, prod_in;
      logic signed [SHIFT_W-1:0]   shifted;
      logic signed [POS_WIDTH-1:0] err_ff, err_in;
      logic                        ovf;

      always_comb begin
         diff_in = DIFF_W'(target[a]) - DIFF_W'(current[a]);
         prod_in = PROD_W'(diff_ff) * PROD_W'($signed({1'b0, cfg.gain}));
         shifted = $signed(prod_ff[PROD_W-1:GAIN_SHIFT]);
         ovf     = !((&shifted[SHIFT_W-1:POS_WIDTH-1]) || !(|shifted[SHIFT_W-1:POS_WIDTH-1]));
         if (ovf) begin
            err_in = shifted[SHIFT_W-1] ? POS_MIN : POS_MAX;
         end else begin
            err_in = shifted[POS_WIDTH-1:0];
         end
      end

      always_ff @(posedge clock) begin
         diff_ff <= diff_in;
         prod_ff <= prod_in;
         err_ff  <= err_in;
      end

      assign err[a] = err_ff;
   end

endmodule

@@ sv/upc_cordic.sv @@
module upc_cordic #(
   parameter int ANGLE_WIDTH = 16
) (
   input  logic                              clock,
   input  logic signed [ANGLE_WIDTH-1:0]     heading,
   output logic signed [upc_pkg::SC_WIDTH-1:0] cos_out,
   output logic signed [upc_pkg::SC_WIDTH-1:0] sin_out
);
   import upc_pkg::*;

   localparam int W  = CORDIC_WIDTH;
   localparam int RW = W - CORDIC_SHIFT;
   localparam logic signed [RW-1:0] ONE = RW'(SC_ONE);

   logic signed [W-1:0] x_ff [0:CORDIC_STEPS];
   logic signed [W-1:0] y_ff [0:CORDIC_STEPS];
   logic signed [W-1:0] z_ff [0:CORDIC_STEPS];
   logic                flip_ff [0:CORDIC_STEPS];

   logic [ANGLE_BITS-1:0] angle;
   logic                  flip_in;
   logic signed [W-1:0]   z_in;

   logic signed [W-1:0]        x_bias, y_bias;
   logic signed [RW-1:0]       x_round, y_round, x_clamp, y_clamp, x_fin, y_fin;
   logic signed [SC_WIDTH-1:0] cos_ff, cos_in, sin_ff, sin_in;

   // fold the angle into the right half plane
   always_comb begin
      angle   = {heading, {(ANGLE_BITS-ANGLE_WIDTH){1'b0}}};
      flip_in = angle[ANGLE_BITS-1] ^ angle[ANGLE_BITS-2];
      z_in    = W'($signed({angle[ANGLE_BITS-1] ^ flip_in, angle[ANGLE_BITS-2:0]}));
   end

   always_ff @(posedge clock) begin
      x_ff[0]    <= W'(CORDIC_START);
      y_ff[0]    <= '0;
      z_ff[0]    <= z_in;
      flip_ff[0] <= flip_in;
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
      always_ff @(posedge clock) begin
         if (!z_ff[i][W-1]) begin
            x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
            z_ff[i+1] <= z_ff[i] - cordic_atan(i);
         end else begin
            x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
            z_ff[i+1] <= z_ff[i] + cordic_atan(i);
         end
         flip_ff[i+1] <= flip_ff[i];
      end
   end

   // round to q1.16, clamp to unit, undo the fold
   always_comb begin
      x_bias  = x_ff[CORDIC_STEPS] + W'(CORDIC_ROUND);
      y_bias  = y_ff[CORDIC_STEPS] + W'(CORDIC_ROUND);
      x_round = $signed(x_bias[W-1:CORDIC_SHIFT]);
      y_round = $signed(y_bias[W-1:CORDIC_SHIFT]);
      if (x_round > ONE) begin
         x_clamp = ONE;
      end else if (x_round < -ONE) begin
         x_clamp = -ONE;
      end else begin
         x_clamp = x_round;
      end
      if (y_round > ONE) begin
         y_clamp = ONE;
      end else if (y_round < -ONE) begin
         y_clamp = -ONE;
      end else begin
         y_clamp = y_round;
      end
      x_fin  = flip_ff[CORDIC_STEPS] ? -x_clamp : x_clamp;
      y_fin  = flip_ff[CORDIC_STEPS] ? -y_clamp : y_clamp;
      cos_in = x_fin[SC_WIDTH-1:0];
      sin_in = y_fin[SC_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      cos_ff <= cos_in;
      sin_ff <= sin_in;
   end

   assign cos_out = cos_ff;
   assign sin_out = sin_ff;

endmodule

@@ sv/upc_rotate.sv @@
module upc_rotate #(
   parameter int POS_WIDTH = 32
) (
   input  logic                                clock,
   input  upc_pkg::cfg_type                    cfg,
   input  logic signed [POS_WIDTH-1:0]         err [3],
   input  logic signed [upc_pkg::SC_WIDTH-1:0] cos_in,
   input  logic signed [upc_pkg::SC_WIDTH-1:0] sin_in,
   output logic signed [POS_WIDTH-1:0]         forward_speed,
   output logic signed [POS_WIDTH-1:0]         yaw_rate,
   output logic signed [POS_WIDTH-1:0]         vertical_velocity
);
   import upc_pkg::*;

   localparam int PW  = POS_WIDTH + SC_WIDTH;
   localparam int TW  = PW - TERM_SHIFT;
   localparam int SW  = TW + 1;
   localparam int LW  = SW + CSR_DATA_WIDTH + 1;
   localparam int LSW = LW - GAIN_SHIFT;
   localparam logic signed [POS_WIDTH-1:0] POS_MAX = {1'b0, {(POS_WIDTH-1){1'b1}}};
   localparam logic signed [POS_WIDTH-1:0] POS_MIN = {1'b1, {(POS_WIDTH-1){1'b0}}};

   logic signed [PW-1:0]        xc_ff, ys_ff, yc_ff, xs_ff;
   logic signed [SW-1:0]        fwd_sum, lat_sum, lat_ff;
   logic signed [POS_WIDTH-1:0] fwd_in, fwd_ff, fwd2_ff, fwd3_ff;
   logic signed [LW-1:0]        lp_ff;
   logic signed [LSW-1:0]       lp_shift;
   logic signed [POS_WIDTH-1:0] turn_in, turn_ff;
   logic signed [POS_WIDTH-1:0] vz_ff [0:ROTATE_LATENCY-1];
   logic                        fwd_ovf, turn_ovf;

   always_comb begin
      fwd_sum = SW'($signed(xc_ff[PW-1:TERM_SHIFT])) + SW'($signed(ys_ff[PW-1:TERM_SHIFT]));
      lat_sum = SW'($signed(yc_ff[PW-1:TERM_SHIFT])) - SW'($signed(xs_ff[PW-1:TERM_SHIFT]));
      fwd_ovf = !((&fwd_sum[SW-1:POS_WIDTH-1]) || !(|fwd_sum[SW-1:POS_WIDTH-1]));
      if (fwd_ovf) begin
         fwd_in = fwd_sum[SW-1] ? POS_MIN : POS_MAX;
      end else begin
         fwd_in = fwd_sum[POS_WIDTH-1:0];
      end
      lp_shift = $signed(lp_ff[LW-1:GAIN_SHIFT]);
      turn_ovf = !((&lp_shift[LSW-1:POS_WIDTH-1]) || !(|lp_shift[LSW-1:POS_WIDTH-1]));
      if (turn_ovf) begin
         turn_in = lp_shift[LSW-1] ? POS_MIN : POS_MAX;
      end else begin
         turn_in = lp_shift[POS_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      xc_ff   <= PW'(err[0]) * PW'(cos_in);
      ys_ff   <= PW'(err[1]) * PW'(sin_in);
      yc_ff   <= PW'(err[1]) * PW'(cos_in);
      xs_ff   <= PW'(err[0]) * PW'(sin_in);
      fwd_ff  <= fwd_in;
      lat_ff  <= lat_sum;
      fwd2_ff <= fwd_ff;
      lp_ff   <= LW'(lat_ff) * LW'($signed({1'b0, cfg.inverse_offset}));
      fwd3_ff <= fwd2_ff;
      turn_ff <= turn_in;
      vz_ff[0] <= err[2];
      for (int k = 1; k < ROTATE_LATENCY; k++) begin
         vz_ff[k] <= vz_ff[k-1];
      end
   end

   assign forward_speed     = fwd3_ff;
   assign yaw_rate          = turn_ff;
   assign vertical_velocity = vz_ff[ROTATE_LATENCY-1];

endmodule

@@ sv/unicycle_point_controller_unit.sv @@
// unicycle point controller: steers a vehicle toward a target point
// request: pulse start with the target and current positions (q16.16) and the
// heading (binary angle); busy stays low, so an item may be started every cycle
// response: rsp_valid is high for one cycle with forward speed, turn rate and
// vertical velocity, all q16.16 and saturated
// the path from start to rsp_valid runs through the 30-step cordic
// (one step per stage) plus its fold and rounding stages and the four
// multiply and saturate stages after it; throughput is one item per cycle
// csr port: write gain (index 0) or inverse offset (index 1), unsigned q8.8,
// by raising csr_write_enable; change them only while no item is in flight
// reset: synchronous, clears the in-flight valid bits and sets both
// registers to 1.0
// the receiver cannot stall: each result is shown for exactly one cycle
module unicycle_point_controller_unit #(
   parameter int POS_WIDTH   = 32,
   parameter int ANGLE_WIDTH = 16
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       start,
   output logic                                       busy,
   input  logic signed [POS_WIDTH-1:0]                req_target_x,
   input  logic signed [POS_WIDTH-1:0]                req_target_y,
   input  logic signed [POS_WIDTH-1:0]                req_target_z,
   input  logic signed [POS_WIDTH-1:0]                req_current_x,
   input  logic signed [POS_WIDTH-1:0]                req_current_y,
   input  logic signed [POS_WIDTH-1:0]                req_current_z,
   input  logic signed [ANGLE_WIDTH-1:0]              req_heading,
   output logic                                       rsp_valid,
   output logic signed [POS_WIDTH-1:0]                rsp_forward_speed,
   output logic signed [POS_WIDTH-1:0]                rsp_yaw_rate,
   output logic signed [POS_WIDTH-1:0]                rsp_vertical_velocity,
   input  logic                                       csr_write_enable,
   input  logic [upc_pkg::CSR_INDEX_WIDTH-1:0]        csr_index,
   input  logic [upc_pkg::CSR_DATA_WIDTH-1:0]         csr_write_data
);
   import upc_pkg::*;

   localparam int ALIGN     = CORDIC_LATENCY - SCALE_LATENCY;
   localparam int TOTAL_LAT = CORDIC_LATENCY + ROTATE_LATENCY;

   cfg_type cfg_ff, cfg_in;
   logic [TOTAL_LAT-1:0] valid_ff, valid_in;

   logic signed [POS_WIDTH-1:0] target [3];
   logic signed [POS_WIDTH-1:0] current [3];
   logic signed [POS_WIDTH-1:0] err [3];
   logic signed [POS_WIDTH-1:0] align_ff [0:ALIGN-1][3];
   logic signed [SC_WIDTH-1:0]  cos_val, sin_val;

   assign busy = 1'b0;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_GAIN:           cfg_in.gain           = csr_write_data;
            CSR_INVERSE_OFFSET: cfg_in.inverse_offset = csr_write_data;
         endcase
      end
      valid_in = {valid_ff[TOTAL_LAT-2:0], start & !busy};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain           <= GAIN_RESET;
         cfg_ff.inverse_offset <= INVERSE_OFFSET_RESET;
         valid_ff              <= '0;
      end else begin
         cfg_ff   <= cfg_in;
         valid_ff <= valid_in;
      end
   end

   assign target[0]  = req_target_x;
   assign target[1]  = req_target_y;
   assign target[2]  = req_target_z;
   assign current[0] = req_current_x;
   assign current[1] = req_current_y;
   assign current[2] = req_current_z;

   upc_scale #(.POS_WIDTH(POS_WIDTH)) u_scale (
      .clock   (clock),
      .cfg     (cfg_ff),
      .target  (target),
      .current (current),
      .err     (err)
   );

   upc_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_cordic (
      .clock   (clock),
      .heading (req_heading),
      .cos_out (cos_val),
      .sin_out (sin_val)
   );

   // hold the scaled errors until the sine and cosine catch up
   always_ff @(posedge clock) begin
      align_ff[0] <= err;
      for (int k = 1; k < ALIGN; k++) begin
         align_ff[k] <= align_ff[k-1];
      end
   end

   upc_rotate #(.POS_WIDTH(POS_WIDTH)) u_rotate (
      .clock             (clock),
      .cfg               (cfg_ff),
      .err               (align_ff[ALIGN-1]),
      .cos_in            (cos_val),
      .sin_in            (sin_val),
      .forward_speed     (rsp_forward_speed),
      .yaw_rate          (rsp_yaw_rate),
      .vertical_velocity (rsp_vertical_velocity)
   );

   assign rsp_valid = valid_ff[TOTAL_LAT-1];

endmodule

@@ sim/unicycle_point_controller_unit_test.sv @@
module unicycle_point_controller_unit_test;

   localparam int POS_W           = 32;
   localparam int ANG_W           = 16;
   localparam int NUM_DIRECTED    = 23;
   localparam int NUM_PHASES      = 8;
   localparam int ITEMS_PER_PHASE = 104;
   localparam int DRAIN_CYCLES    = 40;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int REPORT_LIMIT    = 10;

   localparam logic signed [POS_W-1:0] POS_MAX = 32'sh7FFFFFFF;
   localparam logic signed [POS_W-1:0] POS_MIN = 32'sh80000000;
   localparam logic signed [POS_W-1:0] POS_ONE = 32'sh00010000;
   localparam logic signed [POS_W-1:0] POS_NEG = -32'sd1;

   localparam int     ROT_STEPS   = 30;
   localparam longint CORDIC_INIT = 652032874;
   localparam longint ATAN_STEP [ROT_STEPS] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
      41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
      10, 5, 3, 1
   };

   // -1 picks a random register value
   localparam int PHASE_GAIN [NUM_PHASES] = '{256, 0, 65535, 65535, -1, 1, -1, 128};
   localparam int PHASE_INV  [NUM_PHASES] = '{256, 65535, 0, 65535, -1, 1, -1, 512};
   localparam int PHASE_IDLE [NUM_PHASES] = '{0, 86, 37, 0, 86, 37, 0, 86};

   typedef struct packed {
      logic signed [POS_W-1:0] target_x;
      logic signed [POS_W-1:0] target_y;
      logic signed [POS_W-1:0] target_z;
      logic signed [POS_W-1:0] current_x;
      logic signed [POS_W-1:0] current_y;
      logic signed [POS_W-1:0] current_z;
      logic signed [ANG_W-1:0] heading;
   } pose_item_type;

   typedef struct packed {
      logic signed [POS_W-1:0] forward_speed;
      logic signed [POS_W-1:0] yaw_rate;
      logic signed [POS_W-1:0] vertical_velocity;
   } command_type;

   typedef struct packed {
      pose_item_type item;
      logic          typed;
      command_type   command;
   } directed_row_type;

   logic                                clock;
   logic                                reset;
   logic                                start;
   logic                                busy;
   logic signed [POS_W-1:0]             req_target_x;
   logic signed [POS_W-1:0]             req_target_y;
   logic signed [POS_W-1:0]             req_target_z;
   logic signed [POS_W-1:0]             req_current_x;
   logic signed [POS_W-1:0]             req_current_y;
   logic signed [POS_W-1:0]             req_current_z;
   logic signed [ANG_W-1:0]             req_heading;
   logic                                rsp_valid;
   logic signed [POS_W-1:0]             rsp_forward_speed;
   logic signed [POS_W-1:0]             rsp_yaw_rate;
   logic signed [POS_W-1:0]             rsp_vertical_velocity;
   logic                                csr_write_enable;
   logic [upc_pkg::CSR_INDEX_WIDTH-1:0] csr_index;
   logic [upc_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data;

   logic [15:0] gain_q8 = upc_pkg::GAIN_RESET;
   logic [15:0] inv_q8  = upc_pkg::INVERSE_OFFSET_RESET;
   command_type offered_command;
   command_type pending_commands [$];
   int          errors;
   int          items_accepted;
   int          results_checked;
   int          settings_applied;
   int          stall_cycles;

   // typed rows run under the reset gains of 1.0
   directed_row_type directed_rows [NUM_DIRECTED] = '{
      '{'{32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 16'sh0000}, 1'b1,
        '{32'sd0, 32'sd0, 32'sd0}},
      '{'{32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 16'sh8000}, 1'b1,
        '{32'sd0, 32'sd0, 32'sd0}},
      '{'{POS_MAX, POS_MIN, POS_MAX, POS_MAX, POS_MIN, POS_MIN, 16'sh4000}, 1'b1,
        '{32'sd0, 32'sd0, POS_MAX}},
      '{'{32'sd12345, -32'sd777, POS_MIN, 32'sd12345, -32'sd777, POS_MAX, 16'sh7FFF},
        1'b1, '{32'sd0, 32'sd0, POS_MIN}},
      '{'{32'sd0, 32'sd0, 32'sd1, 32'sd0, 32'sd0, 32'sd0, 16'sh1234}, 1'b1,
        '{32'sd0, 32'sd0, 32'sd1}},
      '{'{32'sd0, 32'sd0, POS_NEG, 32'sd0, 32'sd0, 32'sd0, 16'shC000}, 1'b1,
        '{32'sd0, 32'sd0, POS_NEG}},
      '{'{POS_ONE, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 16'sh0000}, 1'b0, '0},
      '{'{32'sd0, POS_ONE, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 16'sh0000}, 1'b0, '0},
      '{'{POS_ONE, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 16'sh4000}, 1'b0, '0},
      '{'{POS_ONE, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 16'shC000}, 1'b0, '0},
      '{'{POS_ONE, POS_ONE, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 16'sh8000}, 1'b0, '0},
      '{'{POS_ONE, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 16'sh3FFF}, 1'b0, '0},
      '{'{POS_ONE, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 16'sh7FFF}, 1'b0, '0},
      '{'{POS_ONE, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 16'sh8001}, 1'b0, '0},
      '{'{32'sd0, POS_ONE, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 16'shC001}, 1'b0, '0},
      '{'{POS_MAX, 32'sd0, 32'sd0, POS_MIN, 32'sd0, 32'sd0, 16'sh0000}, 1'b0, '0},
      '{'{32'sd0, POS_MAX, 32'sd0, 32'sd0, POS_MIN, 32'sd0, 16'sh0000}, 1'b0, '0},
      '{'{POS_MIN, POS_MIN, 32'sd0, POS_MAX, POS_MAX, 32'sd0, 16'sh2000}, 1'b0, '0},
      '{'{POS_MAX, POS_MAX, 32'sd0, POS_MIN, POS_MIN, 32'sd0, 16'shE000}, 1'b0, '0},
      '{'{32'sd1, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 16'sh1000}, 1'b0, '0},
      '{'{POS_NEG, POS_NEG, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 16'sh6000}, 1'b0, '0},
      '{'{POS_MIN, POS_MIN, POS_MIN, POS_MAX, POS_MAX, POS_MAX, 16'sh8000}, 1'b0, '0},
      '{'{POS_MAX, POS_MAX, POS_MAX, POS_MAX, POS_MAX, POS_MAX, 16'sh7FFF}, 1'b0, '0}
   };

   unicycle_point_controller_unit #(
      .POS_WIDTH   (POS_W),
      .ANGLE_WIDTH (ANG_W)
   ) u_dut (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_target_x          (req_target_x),
      .req_target_y          (req_target_y),
      .req_target_z          (req_target_z),
      .req_current_x         (req_current_x),
      .req_current_y         (req_current_y),
      .req_current_z         (req_current_z),
      .req_heading           (req_heading),
      .rsp_valid             (rsp_valid),
      .rsp_forward_speed     (rsp_forward_speed),
      .rsp_yaw_rate          (rsp_yaw_rate),
      .rsp_vertical_velocity (rsp_vertical_velocity),
      .csr_write_enable      (csr_write_enable),
      .csr_index             (csr_index),
      .csr_write_data        (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic logic signed [POS_W-1:0] saturate(input longint v);
      if (v > longint'(POS_MAX)) return POS_MAX;
      if (v < longint'(POS_MIN)) return POS_MIN;
      return v[POS_W-1:0];
   endfunction

   function automatic command_type control_law(input pose_item_type it, input logic [15:0] gain,
                                               input logic [15:0] inv);
      logic [31:0] angle;
      logic        flip;
      longint      g;
      longint      x;
      longint      y;
      longint      z;
      longint      nx;
      longint      ex;
      longint      ey;
      longint      lat;
      command_type cmd;
      g = longint'({48'd0, gain});
      angle = {it.heading, {(32-ANG_W){1'b0}}};
      // fold the back half plane onto the front one
      flip = (angle[31:30] == 2'b01) || (angle[31:30] == 2'b10);
      if (flip) angle = angle + 32'h80000000;
      z = longint'($signed(angle));
      x = CORDIC_INIT;
      y = 0;
      for (int i = 0; i < ROT_STEPS; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y  = y + (x >>> i);
            z  = z - ATAN_STEP[i];
         end else begin
            nx = x + (y >>> i);
            y  = y - (x >>> i);
            z  = z + ATAN_STEP[i];
         end
         x = nx;
      end
      x = (x + 8192) >>> 14;
      y = (y + 8192) >>> 14;
      if (x > 65536) x = 65536;
      if (x < -65536) x = -65536;
      if (y > 65536) y = 65536;
      if (y < -65536) y = -65536;
      if (flip) begin
         x = -x;
         y = -y;
      end
      ex = saturate(((longint'($signed(it.target_x)) - longint'($signed(it.current_x))) * g)
                    >>> 8);
      ey = saturate(((longint'($signed(it.target_y)) - longint'($signed(it.current_y))) * g)
                    >>> 8);
      cmd.vertical_velocity = saturate(((longint'($signed(it.target_z))
                                         - longint'($signed(it.current_z))) * g) >>> 8);
      cmd.forward_speed = saturate(((ex * x) >>> 16) + ((ey * y) >>> 16));
      lat = ((ey * x) >>> 16) - ((ex * y) >>> 16);
      cmd.yaw_rate = saturate((lat * longint'({48'd0, inv})) >>> 8);
      return cmd;
   endfunction

   function automatic logic signed [POS_W-1:0] nearby(input logic signed [POS_W-1:0] base);
      logic signed [POS_W-1:0] d;
      d = $signed($urandom) >>> $urandom_range(8, 31);
      return base - d;
   endfunction

   function automatic logic signed [POS_W-1:0] extreme_value();
      case ($urandom_range(0, 4))
         0: return POS_MAX;
         1: return POS_MIN;
         2: return 32'sd0;
         3: return POS_NEG;
         default: return POS_ONE;
      endcase
   endfunction

   task automatic send_item(input pose_item_type it, input logic typed,
                            input command_type typed_cmd, input int idle_pct);
      @(negedge clock);
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start         <= 1'b1;
      req_target_x  <= it.target_x;
      req_target_y  <= it.target_y;
      req_target_z  <= it.target_z;
      req_current_x <= it.current_x;
      req_current_y <= it.current_y;
      req_current_z <= it.current_z;
      req_heading   <= it.heading;
      offered_command = typed ? typed_cmd : control_law(it, gain_q8, inv_q8);
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic settle();
      @(negedge clock);
      start <= 1'b0;
      while (pending_commands.size() != 0) @(negedge clock);
   endtask

   task automatic write_register(input logic [upc_pkg::CSR_INDEX_WIDTH-1:0] index,
                                 input logic [15:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      if (index == upc_pkg::CSR_GAIN) gain_q8 = data;
      else inv_q8 = data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   always @(posedge clock) begin
      command_type want;
      logic        moved;
      moved = 1'b0;
      if (!reset) begin
         if (start && !busy) begin
            pending_commands.push_back(offered_command);
            items_accepted++;
            moved = 1'b1;
         end
         if (rsp_valid) begin
            moved = 1'b1;
            if (pending_commands.size() == 0) begin
               errors++;
               if (errors <= REPORT_LIMIT)
                  $display("unexpected result: fwd %h yaw %h vz %h", rsp_forward_speed,
                           rsp_yaw_rate, rsp_vertical_velocity);
            end else begin
               want = pending_commands.pop_front();
               results_checked++;
               if (rsp_forward_speed !== want.forward_speed ||
                   rsp_yaw_rate !== want.yaw_rate ||
                   rsp_vertical_velocity !== want.vertical_velocity) begin
                  errors++;
                  if (errors <= REPORT_LIMIT)
                     $display("mismatch on result %0d: fwd %h/%h yaw %h/%h vz %h/%h",
                              results_checked, want.forward_speed, rsp_forward_speed,
                              want.yaw_rate, rsp_yaw_rate, want.vertical_velocity,
                              rsp_vertical_velocity);
               end
            end
         end
      end
      stall_cycles <= moved ? 0 : stall_cycles + 1;
   end

   initial begin
      while (stall_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("watchdog: no item or result moved for %0d cycles", WATCHDOG_LIMIT);
      $display("unicycle_point_controller_unit_test NOT OK");
      $finish;
   end

   initial begin
      pose_item_type it;
      int            gain_value;
      int            inv_value;
      int            kind;
      reset            = 1'b1;
      start            = 1'b0;
      req_target_x     = '0;
      req_target_y     = '0;
      req_target_z     = '0;
      req_current_x    = '0;
      req_current_y    = '0;
      req_current_z    = '0;
      req_heading      = '0;
      csr_write_enable = 1'b0;
      csr_index        = upc_pkg::CSR_GAIN;
      csr_write_data   = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int r = 0; r < NUM_DIRECTED; r++)
         send_item(directed_rows[r].item, directed_rows[r].typed, directed_rows[r].command, 37);

      for (int p = 0; p < NUM_PHASES; p++) begin
         settle();
         gain_value = (PHASE_GAIN[p] < 0) ? $urandom_range(0, 65535) : PHASE_GAIN[p];
         inv_value  = (PHASE_INV[p] < 0) ? $urandom_range(0, 65535) : PHASE_INV[p];
         write_register(upc_pkg::CSR_GAIN, gain_value[15:0]);
         write_register(upc_pkg::CSR_INVERSE_OFFSET, inv_value[15:0]);
         settings_applied++;
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            kind = $urandom_range(0, 9);
            it.target_x  = $urandom;
            it.target_y  = $urandom;
            it.target_z  = $urandom;
            it.current_x = $urandom;
            it.current_y = $urandom;
            it.current_z = $urandom;
            if (kind >= 3) begin
               // vehicle close to the target so results stay mostly in range
               it.current_x = nearby(it.target_x);
               it.current_y = nearby(it.target_y);
               it.current_z = nearby(it.target_z);
            end else if (kind == 2) begin
               it.target_x  = extreme_value();
               it.target_y  = extreme_value();
               it.target_z  = extreme_value();
               it.current_x = extreme_value();
               it.current_y = extreme_value();
               it.current_z = extreme_value();
            end
            if ($urandom_range(0, 4) == 0)
               it.heading = ANG_W'(($urandom_range(0, 3) << 14) + $urandom_range(0, 4) - 2);
            else
               it.heading = ANG_W'($urandom);
            send_item(it, 1'b0, '0, PHASE_IDLE[p]);
         end
      end

      settle();
      repeat (DRAIN_CYCLES) @(negedge clock);
      errors += pending_commands.size();
      $display("checked %0d results from %0d items over %0d register settings,",
               results_checked, items_accepted, settings_applied + 1);
      $display("including zero and full-scale gains and start gaps of 0, 37 and 86 percent");
      if (errors == 0)
         $display("unicycle_point_controller_unit_test OK");
      else
         $display("unicycle_point_controller_unit_test NOT OK");
      $finish;
   end

endmodule
